FILE: src/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg: shared types and constants for the bitmap page allocator
// Payload structs, request kinds, map geometry.
// ----------------------------------------------------------------------------
package bpa_pkg;

	localparam int MAX_PAGES     = 4096;
	localparam int PAGE_SHIFT    = 12;
	localparam int MAP_WORD_BITS = 32;
	localparam int MAP_DEPTH     = (MAX_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
	localparam int AW            = $clog2(MAP_DEPTH);
	localparam int BW            = $clog2(MAP_WORD_BITS);
	localparam int PW            = AW + BW;
	localparam int CW            = 13;

	typedef enum logic [2:0] {
		KIND_ALLOC   = 3'd0,
		KIND_FREE    = 3'd1,
		KIND_RESERVE = 3'd2,
		KIND_TEST    = 3'd3,
		KIND_CLEAR   = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WIPE,
		ST_SCAN,
		ST_MARK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [12:0] run_length;
		logic [23:0] free_address;
		logic [11:0] page_number;
	} req_t;

	typedef struct packed {
		logic        ok;
		logic [23:0] run_address;
		logic [12:0] free_total;
		logic [12:0] used_total;
		logic [12:0] reserved_total;
	} rsp_t;

endpackage

FILE: src/bitmap_page_allocator_unit.sv
// ----------------------------------------------------------------------------
// bitmap_page_allocator_unit: bitmap page-frame allocator
// One-bit-per-page map in a single-port synchronous RAM, walked page by page
// by a read-modify-write sequencer.
// ----------------------------------------------------------------------------
// Timing: one request at a time; busy stays high until the result strobe.
// Each map page visited is a map word read, then the bit check and, on a
// change, the write back. Allocate scans for a free run and then marks
// its pages; free walks its pages one by one. Reserve and test visit a
// single page. Clear, a register write and reset sweep all map words, one
// per cycle (MAP_DEPTH words, 128 by default), with busy high. cfg_ready
// is low while a request is running.
// The done strobe is high for one cycle only; the receiver cannot stall it.
module bitmap_page_allocator_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  bpa_pkg::req_t  request,
	output logic           done,
	output bpa_pkg::rsp_t  result,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [12:0]    cfg_data
);
	import bpa_pkg::*;

	logic [MAP_WORD_BITS-1:0] map_mem [MAP_DEPTH];
	logic [MAP_WORD_BITS-1:0] rd_q;

	state_t state_q, state_n;
	req_t   req_q;
	logic [CW-1:0] limit_q, free_q, used_q, rsv_q;
	logic [CW:0]   page_q;      // current page
	logic [CW-1:0] run_q;       // pages found / left
	logic [CW-1:0] start_q;
	logic          phase_q;     // 0: read issued, 1: data valid
	logic          ok_q;
	logic          wipe_rsp_q;  // sweep came from a clear request
	logic [AW-1:0] wipe_q;

	// combinational controls
	logic          we;
	logic [AW-1:0] addr;
	logic [MAP_WORD_BITS-1:0] wdata;
	logic          bit_now;
	logic [CW-1:0] managed;

	assign managed = (cfg_data > CW'(MAX_PAGES)) ? CW'(MAX_PAGES) : cfg_data;
	assign bit_now = rd_q[page_q[BW-1:0]];

	always_ff @(posedge clk) begin
		if (we)
			map_mem[addr] <= wdata;
		rd_q <= map_mem[addr];
	end

	always_comb begin
		we    = 1'b0;
		addr  = page_q[PW-1:BW];
		wdata = rd_q;
		wdata[page_q[BW-1:0]] = (state_q == ST_MARK) ? 1'b1 : !(req_q.kind == KIND_FREE);
		if (state_q == ST_WIPE) begin
			we    = 1'b1;
			addr  = wipe_q;
			wdata = '0;
		end else if ((state_q == ST_MARK || state_q == ST_SCAN) && phase_q) begin
			// write back only when the bit changes
			if (state_q == ST_MARK)
				we = !bit_now;
			else if (req_q.kind == KIND_FREE)
				we = bit_now && page_q < {1'b0, limit_q};
			else if (req_q.kind == KIND_RESERVE)
				we = !bit_now && page_q < {1'b0, limit_q};
		end
	end

	assign busy      = state_q != ST_IDLE;
	assign cfg_ready = state_q == ST_IDLE && !start;

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cfg_valid && cfg_ready) begin
					state_n = ST_WIPE;
				end else if (start) begin
					unique case (request.kind) inside
						KIND_ALLOC: begin
							if (request.run_length != '0 && request.run_length <= free_q)
								state_n = ST_SCAN;
							else
								state_n = ST_DONE;
						end
						KIND_FREE: state_n = (request.run_length == '0) ? ST_DONE : ST_SCAN;
						KIND_RESERVE, KIND_TEST: state_n = ST_SCAN;
						KIND_CLEAR: state_n = ST_WIPE;
						default: state_n = ST_DONE;
					endcase
				end
			end
			ST_WIPE: if (wipe_q == AW'(MAP_DEPTH - 1))
				state_n = wipe_rsp_q ? ST_DONE : ST_IDLE;
			ST_SCAN: if (phase_q) begin
				unique case (req_q.kind)
					KIND_ALLOC: begin
						if (page_q >= {1'b0, limit_q})
							state_n = ST_DONE;
						else if (!bit_now && run_q + 1'b1 >= req_q.run_length)
							state_n = ST_MARK;
					end
					KIND_FREE: if (run_q == CW'(1) || page_q >= {1'b0, limit_q})
						state_n = ST_DONE;
					default: state_n = ST_DONE;
				endcase
			end
			ST_MARK: if (phase_q && run_q == CW'(1))
				state_n = ST_DONE;
			ST_DONE: state_n = ST_IDLE;
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_WIPE;
		else
			state_q <= state_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_q      <= '0;
			limit_q    <= CW'(MAX_PAGES);
			free_q     <= CW'(MAX_PAGES);
			used_q     <= '0;
			rsv_q      <= '0;
			wipe_q     <= '0;
			wipe_rsp_q <= 1'b0;
			phase_q    <= 1'b0;
			ok_q       <= 1'b0;
			page_q     <= '0;
			run_q      <= '0;
			start_q    <= '0;
			done       <= 1'b0;
			result     <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					phase_q <= 1'b0;
					ok_q    <= 1'b0;
					if (cfg_valid && cfg_ready) begin
						limit_q    <= managed;
						free_q     <= managed;
						used_q     <= '0;
						rsv_q      <= '0;
						wipe_q     <= '0;
						wipe_rsp_q <= 1'b0;
					end else if (start) begin
						req_q <= request;
						run_q <= '0;
						unique case (request.kind) inside
							KIND_ALLOC: begin
								page_q <= '0;
							end
							KIND_FREE: begin
								page_q  <= (CW+1)'(request.free_address[23:PAGE_SHIFT]);
								run_q   <= request.run_length;
								ok_q    <= 1'b1;
							end
							KIND_RESERVE, KIND_TEST: begin
								page_q  <= (CW+1)'(request.page_number);
								ok_q    <= request.kind == KIND_RESERVE;
							end
							KIND_CLEAR: begin
								free_q     <= limit_q;
								used_q     <= '0;
								rsv_q      <= '0;
								wipe_q     <= '0;
								wipe_rsp_q <= 1'b1;
								ok_q       <= 1'b1;
							end
							default: ;
						endcase
					end
				end
				ST_WIPE: begin
					wipe_q  <= wipe_q + 1'b1;
				end
				ST_SCAN: begin
					phase_q <= !phase_q;
					if (phase_q) begin
						unique case (req_q.kind)
							KIND_ALLOC: begin
								if (page_q >= {1'b0, limit_q}) begin
									// no run found
								end else if (!bit_now) begin
									if (run_q == '0)
										start_q <= page_q[CW-1:0];
									run_q <= run_q + 1'b1;
									if (run_q + 1'b1 >= req_q.run_length) begin
										// mark from the run's start
										page_q  <= {1'b0, (run_q == '0) ? page_q[CW-1:0]
										                                : start_q};
									end else
										page_q <= page_q + 1'b1;
								end else begin
									run_q  <= '0;
									page_q <= page_q + 1'b1;
								end
							end
							KIND_FREE: begin
								if (page_q < {1'b0, limit_q} && bit_now) begin
									free_q <= free_q + 1'b1;
									if (used_q != '0)
										used_q <= used_q - 1'b1;
								end
								run_q  <= run_q - 1'b1;
								page_q <= page_q + 1'b1;
							end
							KIND_RESERVE: begin
								if (page_q < {1'b0, limit_q} && !bit_now) begin
									rsv_q  <= rsv_q + 1'b1;
									free_q <= free_q - 1'b1;
								end
							end
							default: begin
								ok_q    <= page_q < {1'b0, limit_q} && !bit_now;
							end
						endcase
					end
				end
				ST_MARK: begin
					phase_q <= !phase_q;
					if (phase_q) begin
						used_q <= used_q + 1'b1;
						free_q <= free_q - 1'b1;
						run_q  <= run_q - 1'b1;
						page_q <= page_q + 1'b1;
						if (run_q == CW'(1))
							ok_q    <= 1'b1;
					end
				end
				ST_DONE: begin
					done                  <= 1'b1;
					result.ok             <= ok_q;
					result.run_address    <= (ok_q && req_q.kind == KIND_ALLOC)
						? 24'({start_q, {PAGE_SHIFT{1'b0}}}) : '0;
					result.free_total     <= free_q;
					result.used_total     <= used_q;
					result.reserved_total <= rsv_q;
				end
				default: ;
			endcase
		end
	end

endmodule
